@@ design/linear_probe_hash_table_unit_assert.svh @@
// ----------------------------------------------------------------------------
// linear probe hash table assertion macros
// concurrent assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_TABLE_UNIT_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_UNIT_ASSERT_SVH

`ifndef SYNTH
`define LPHT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define LPHT_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define LPHT_ASSERT(lbl, prop, msg)
`define LPHT_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

@@ design/lpht_pkg.sv @@
// ----------------------------------------------------------------------------
// lpht_pkg
// shared types and constants of the linear probe hash table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpht_pkg;

    localparam int SLOT_W    = 4;
    localparam int SLOTS     = 1 << SLOT_W;
    localparam int CNT_W     = SLOT_W + 1;
    localparam int KEY_W     = 31;
    localparam int VAL_W     = 32;
    localparam int SLOT_F_W  = 4;
    localparam int ENTRIES_W = 5;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_UPDATED   = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_DELETED   = 3'd4,
        ST_FULL      = 3'd5
    } t_status;

    typedef struct packed {
        logic [1:0]       operation;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value_word;
    } t_in;

    typedef struct packed {
        t_status              status;
        logic [SLOT_F_W-1:0]  slot;
        logic [VAL_W-1:0]     found_value;
        logic [ENTRIES_W-1:0] entries;
    } t_out;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_entry;

    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        t_entry            wr_data;
    } t_mem_req;

endpackage

@@ design/lpht_mem.sv @@
// ----------------------------------------------------------------------------
// lpht_mem
// slot key and value store, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpht_mem
    import lpht_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_entry   o_rd_data
);

    t_entry r_mem [SLOTS];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/lpht_ctrl.sv @@
// ----------------------------------------------------------------------------
// lpht_ctrl
// probe sequencer: walks slots one per cycle, keeps used bits and count
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpht_ctrl
    import lpht_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in      i_in_data,
    output logic     o_busy,
    input  logic     i_out_ready,
    output logic     o_res_valid,
    output t_out     o_res,
    output t_mem_req o_mem,
    input  t_entry   i_rd_data
);

    typedef enum logic {
        S_IDLE,
        S_PROBE
    } t_state;

    t_state            r_state, n_state;
    logic [SLOT_W-1:0] r_p, n_p;
    logic [SLOT_W-1:0] r_n, n_n;
    logic [1:0]        r_op, n_op;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [VAL_W-1:0]  r_val, n_val;
    logic [SLOTS-1:0]  r_used, n_used;
    logic [CNT_W-1:0]  r_count, n_count;

    logic hit, empty, last, bad_op, decide;

    assign empty  = !r_used[r_p];
    assign hit    = r_used[r_p] && (i_rd_data.key == r_key);
    assign last   = (r_n == SLOT_W'(SLOTS - 1));
    assign bad_op = (r_op != OP_INSERT) && (r_op != OP_LOOKUP) && (r_op != OP_DELETE);
    assign decide = empty || hit || last || bad_op;

    always_comb begin
        n_state     = r_state;
        n_p         = r_p;
        n_n         = r_n;
        n_op        = r_op;
        n_key       = r_key;
        n_val       = r_val;
        n_used      = r_used;
        n_count     = r_count;
        o_mem       = '0;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.status = ST_NOT_FOUND;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op          = i_in_data.operation;
                    n_key         = i_in_data.key;
                    n_val         = i_in_data.value_word;
                    n_p           = i_in_data.key[SLOT_W-1:0];
                    n_n           = '0;
                    o_mem.rd_en   = 1'b1;
                    o_mem.rd_addr = i_in_data.key[SLOT_W-1:0];
                    n_state       = S_PROBE;
                end
            end
            S_PROBE: begin
                if (decide) begin
                    if (i_out_ready) begin
                        o_res_valid = 1'b1;
                        n_state     = S_IDLE;
                        if (!bad_op) begin
                            case (r_op)
                                OP_INSERT: begin
                                    if (hit) begin
                                        o_mem.wr_en   = 1'b1;
                                        o_mem.wr_addr = r_p;
                                        o_mem.wr_data = '{key: r_key, value: r_val};
                                        o_res.status  = ST_UPDATED;
                                        o_res.slot    = SLOT_F_W'(r_p);
                                    end else if (!empty ||
                                                 r_count >= CNT_W'(SLOTS - 2)) begin
                                        o_res.status = ST_FULL;
                                    end else begin
                                        o_mem.wr_en   = 1'b1;
                                        o_mem.wr_addr = r_p;
                                        o_mem.wr_data = '{key: r_key, value: r_val};
                                        n_used[r_p]   = 1'b1;
                                        n_count       = r_count + 1'b1;
                                        o_res.status  = ST_INSERTED;
                                        o_res.slot    = SLOT_F_W'(r_p);
                                    end
                                end
                                OP_LOOKUP: begin
                                    if (hit) begin
                                        o_res.status      = ST_FOUND;
                                        o_res.slot        = SLOT_F_W'(r_p);
                                        o_res.found_value = i_rd_data.value;
                                    end
                                end
                                OP_DELETE: begin
                                    if (hit) begin
                                        n_used[r_p] = 1'b0;
                                        if (r_count != '0) begin
                                            n_count = r_count - 1'b1;
                                        end
                                        o_res.status = ST_DELETED;
                                        o_res.slot   = SLOT_F_W'(r_p);
                                    end
                                end
                                default: begin
                                    o_res.status = ST_NOT_FOUND;
                                end
                            endcase
                        end
                        o_res.entries = ENTRIES_W'(n_count);
                    end
                end else begin
                    n_p           = r_p + 1'b1;
                    n_n           = r_n + 1'b1;
                    o_mem.rd_en   = 1'b1;
                    o_mem.rd_addr = r_p + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_count <= n_count;
        end
        r_p   <= n_p;
        r_n   <= n_n;
        r_op  <= n_op;
        r_key <= n_key;
        r_val <= n_val;
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

@@ design/linear_probe_hash_table_unit.sv @@
// ----------------------------------------------------------------------------
// linear_probe_hash_table_unit
// open addressing hash table with linear probing over 16 slots
// ----------------------------------------------------------------------------
// Input channel (i_in_valid, o_in_stall, i_in_data) carries one operation:
// insert or update, lookup or delete of a 31-bit key with a 32-bit value.
// Output channel (o_out_valid, i_out_stall, o_out_data) returns one result
// per operation: status, slot, found value and live entry count.
// One operation is in flight at a time. After the accept edge the sequencer
// reads one slot per cycle from the key/value memory, starting at the home
// slot (low key bits), until it meets the key, an empty slot, an invalid
// operation code, or has seen all 16 slots, so 1 to 16 slots are probed.
// The result is registered when the probe ends, and the next operation is
// taken after that. The single memory read port sets this pace.
// New keys are refused with table full once 14 entries are live.
// Reset clears the used bits and the entry count, so the table is empty
// and ready right after reset.
// A stalled result stays in the output register; the sequencer waits with
// its finished operation and the input stays stalled until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "linear_probe_hash_table_unit_assert.svh"

module linear_probe_hash_table_unit
    import lpht_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    t_mem_req mem_req;
    t_entry   rd_data;
    logic     busy;
    logic     out_ready;
    logic     res_valid;
    t_out     res;
    logic     r_out_valid;
    t_out     r_out_data;

    assign out_ready  = !r_out_valid || !i_out_stall;
    assign o_in_stall = busy;

    lpht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_busy      (busy),
        .i_out_ready (out_ready),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_mem       (mem_req),
        .i_rd_data   (rd_data)
    );

    lpht_mem u_mem (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (res_valid) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `LPHT_ASSERT(a_res_fits, res_valid |-> out_ready, "result produced into full output register")
    `LPHT_ASSERT_NEXT(a_res_shows, res_valid, o_out_valid, "result not shown after transfer")
    `LPHT_ASSERT(a_count_limit, o_out_valid |-> (o_out_data.entries <= ENTRIES_W'(SLOTS - 2)), "entry count above limit")
    `LPHT_ASSERT(a_value_only_hit, (o_out_valid && o_out_data.status != ST_FOUND) |-> (o_out_data.found_value == '0), "value returned without lookup hit")
    `LPHT_ASSERT(a_no_mem_clash, !(mem_req.rd_en && mem_req.wr_en), "read and write in same cycle")

endmodule

@@ test/lpht_checker.sv @@
// ----------------------------------------------------------------------------
// lpht_checker
// watches both channels of the hash table, tracks the table contents and
// compares every result transfer with the predicted status, slot, value
// and entry count
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpht_checker
    import lpht_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_stall,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_stall,
    input  t_out i_out_data,
    output int   o_fail_count,
    output int   o_pending
);

    logic [KEY_W-1:0] key_mem [SLOTS];
    logic [VAL_W-1:0] val_mem [SLOTS];
    logic [SLOTS-1:0] live;
    logic [CNT_W-1:0] live_count;
    t_out             replies_due [$];
    int               fails = 0;
    int               due_n = 0;

    assign o_fail_count = fails;
    assign o_pending    = due_n;

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        fails++;
    endtask

    function automatic t_out apply_table_op(input t_in op);
        t_out              r;
        logic [SLOT_W-1:0] p;
        logic [SLOT_W-1:0] pos;
        logic              hit;
        logic              has_empty;
        logic              done;
        r = '{status: ST_NOT_FOUND, slot: '0, found_value: '0, entries: '0};
        p = op.key[SLOT_W-1:0];
        pos = '0;
        hit = 1'b0;
        has_empty = 1'b0;
        done = 1'b0;
        // linear probe, wraps through the 4-bit index
        for (int n = 0; n < SLOTS && !done; n++) begin
            if (!live[p]) begin
                has_empty = 1'b1;
                pos = p;
                done = 1'b1;
            end else if (key_mem[p] == op.key) begin
                hit = 1'b1;
                pos = p;
                done = 1'b1;
            end else begin
                p = p + 1'b1;
            end
        end
        case (op.operation)
            OP_INSERT: begin
                if (hit) begin
                    val_mem[pos] = op.value_word;
                    r.status = ST_UPDATED;
                    r.slot = pos;
                end else if (!has_empty || int'(live_count) + 2 >= SLOTS) begin
                    r.status = ST_FULL;
                end else begin
                    key_mem[pos] = op.key;
                    val_mem[pos] = op.value_word;
                    live[pos] = 1'b1;
                    live_count = live_count + 1'b1;
                    r.status = ST_INSERTED;
                    r.slot = pos;
                end
            end
            OP_LOOKUP: begin
                if (hit) begin
                    r.status = ST_FOUND;
                    r.slot = pos;
                    r.found_value = val_mem[pos];
                end
            end
            OP_DELETE: begin
                if (hit) begin
                    live[pos] = 1'b0;
                    if (live_count > 0) begin
                        live_count = live_count - 1'b1;
                    end
                    r.status = ST_DELETED;
                    r.slot = pos;
                end
            end
            default: begin
            end
        endcase
        r.entries = live_count;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            live = '0;
            live_count = '0;
            replies_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (replies_due.size() == 0) begin
                    report_mismatch("result transfer with nothing outstanding");
                end else begin
                    want = replies_due.pop_front();
                    if (i_out_data.status !== want.status) begin
                        report_mismatch($sformatf("status got %0d expected %0d",
                            i_out_data.status, want.status));
                    end
                    if (i_out_data.slot !== want.slot) begin
                        report_mismatch($sformatf("slot got %0d expected %0d",
                            i_out_data.slot, want.slot));
                    end
                    if (i_out_data.found_value !== want.found_value) begin
                        report_mismatch($sformatf("found_value got %h expected %h",
                            i_out_data.found_value, want.found_value));
                    end
                    if (i_out_data.entries !== want.entries) begin
                        report_mismatch($sformatf("entries got %0d expected %0d",
                            i_out_data.entries, want.entries));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                replies_due.push_back(apply_table_op(i_in_data));
            end
        end
        due_n = replies_due.size();
    end

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// drives the hash table with directed and random operations under several
// idle and stall patterns, including a long output hold-off, and reports
// the verdict from the checker's failure count
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import lpht_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int POOL_N = 20;
    localparam int PHASE_ITEMS = 475;
    localparam int CYCLE_LIMIT = 600000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    t_in  in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    t_out out_data;
    logic hold_on = 1'b0;
    logic hold_go = 1'b0;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int send_pct = 0;
    int recv_pct = 0;
    int ins_pct = 50;

    logic [KEY_W-1:0] key_pool [POOL_N];

    linear_probe_hash_table_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    lpht_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk) begin
        out_stall <= hold_on || ($urandom_range(99) < recv_pct);
    end

    // long output hold-off while the sender keeps offering
    initial begin
        wait (hold_go);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (300) @(posedge clk);
        hold_on <= 1'b0;
    end

    function automatic t_in mk_op(input logic [1:0] op, input logic [KEY_W-1:0] key,
                                  input logic [VAL_W-1:0] val);
        t_in item;
        item.operation = op;
        item.key = key;
        item.value_word = val;
        return item;
    endfunction

    function automatic t_in random_op();
        int unsigned roll;
        t_in         item;
        roll = $urandom_range(99);
        if (roll < ins_pct) begin
            item.operation = OP_INSERT;
        end else if (roll < ins_pct + (96 - ins_pct) / 2) begin
            item.operation = OP_LOOKUP;
        end else if (roll < 96) begin
            item.operation = OP_DELETE;
        end else begin
            item.operation = OP_UNUSED;
        end
        if ($urandom_range(9) == 0) begin
            item.key = KEY_W'($urandom());
        end else begin
            item.key = key_pool[$urandom_range(POOL_N - 1)];
        end
        item.value_word = $urandom();
        return item;
    endfunction

    task automatic refresh_pool();
        int unsigned base;
        base = $urandom_range(15);
        // homes packed into a window of six slots, wrapping past the top
        for (int i = 0; i < POOL_N; i++) begin
            key_pool[i] = (KEY_W'($urandom()) & ~KEY_W'(15))
                | KEY_W'((base + $urandom_range(5)) % SLOTS);
        end
    endtask

    task automatic drive_op(input t_in item);
        while ($urandom_range(99) < send_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        do @(posedge clk); while (in_stall);
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        drive_op(mk_op(OP_LOOKUP, 0, 0));
        drive_op(mk_op(OP_DELETE, 0, 0));
        drive_op(mk_op(OP_INSERT, 0, 0));
        drive_op(mk_op(OP_INSERT, 31'h7fffffff, 32'hffffffff));
        drive_op(mk_op(OP_INSERT, 16, 32'ha5a5a5a5));
        drive_op(mk_op(OP_INSERT, 31, 32'h5a5a5a5a));
        drive_op(mk_op(OP_INSERT, 0, 32'h12345678));
        drive_op(mk_op(OP_LOOKUP, 31, 32'hffffffff));
        drive_op(mk_op(OP_UNUSED, 5, 32'hffffffff));
        drive_op(mk_op(OP_DELETE, 16, 0));
        // chain broken by the delete above
        drive_op(mk_op(OP_LOOKUP, 31, 0));
        for (int i = 0; i < 11; i++) begin
            drive_op(mk_op(OP_INSERT, KEY_W'(40 + i), $urandom()));
        end
        drive_op(mk_op(OP_INSERT, 99, 32'h0badf00d));
        drive_op(mk_op(OP_INSERT, 40, 0));
        drive_op(mk_op(OP_LOOKUP, 31'h7fffffff, 0));

        for (int i = 0; i < 11; i++) begin
            key_pool[i] = KEY_W'(40 + i);
        end
        key_pool[11] = 0;
        key_pool[12] = 16;
        key_pool[13] = 31;
        key_pool[14] = 31'h7fffffff;
        for (int i = 15; i < POOL_N; i++) begin
            key_pool[i] = KEY_W'($urandom());
        end

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_pct = 0;
                    recv_pct = 0;
                    hold_go = 1'b1;
                end
                1: begin
                    send_pct = 61;
                    recv_pct = 0;
                end
                2: begin
                    send_pct = 0;
                    recv_pct = 61;
                end
                default: begin
                    send_pct = 31;
                    recv_pct = 31;
                end
            endcase
            if (phase != 0) begin
                refresh_pool();
            end
            ins_pct = (phase % 2 == 0) ? 55 : 40;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                drive_op(random_op());
            end
        end

        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
